// ----- hdl/unsorted_key_table_assert.svh -----
// Assertion macros used by the checker file.
`ifndef UNSORTED_KEY_TABLE_ASSERT_SVH
`define UNSORTED_KEY_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define UKT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define UKT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/ukt_pkg.sv -----
`default_nettype none
package ukt_pkg;
    localparam int CAPACITY = 32;
    localparam int KEY_BITS = 32;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = 6;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0, OP_DEL_ONE = 3'd1, OP_DEL_ALL = 3'd2, OP_LOOKUP = 3'd3,
        OP_CLEAR = 3'd4, OP_REWIND = 3'd5, OP_NEXT = 3'd6, OP_SPLIT = 3'd7
    } op_t;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_DUP  = 3'd2;
    localparam logic [2:0] ST_MISS = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture op and key
        logic scan_rst;  // scan index to zero
        logic scan_inc;  // advance scan index
        logic rd;        // read entry at scan index
        logic rd_last;   // read entry at count-1
        logic rd_pos;    // read entry at read position
        logic wr_append; // write key at count, count+1
        logic wr_move;   // write moved entry at scan index, count-1
        logic clr;       // count to zero
        logic rewind;    // read position to zero
        logic pos_inc;   // read position +1
        logic emit;      // load output register
        logic [2:0] status;
        logic found;
        logic use_val;
        logic below_en;
        logic last;
    } ukt_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        op_t  op;
        logic match;      // registered entry equals key
        logic scan_done;  // scan index reached count
        logic scan_final; // scan index is count-1
        logic full;
        logic empty;
        logic pos_ok;     // read position below count
        logic out_busy;   // output register holds a result m_ready has not taken
    } ukt_sts_t;
endpackage
`default_nettype wire

// ----- hdl/ukt_datapath.sv -----
`default_nettype none
module ukt_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [2:0]         in_op,
    input  wire logic [31:0]        in_key,
    input  wire ukt_pkg::ukt_cmd_t  cmd,
    output ukt_pkg::ukt_sts_t       sts,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic [2:0]              m_status,
    output logic                    m_found,
    output logic [31:0]             m_value,
    output logic                    m_below_pivot,
    output logic                    m_last,
    output logic [5:0]              m_entry_count,
    output logic                    m_is_full,
    output logic                    m_is_empty
);
    import ukt_pkg::*;

    logic [KEY_BITS-1:0] mem [CAPACITY];
    logic [KEY_BITS-1:0] rdata_reg;
    logic [KEY_BITS-1:0] key_reg;
    op_t                 op_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [CNT_W-1:0]    cnt_m1;
    logic [IDX_W-1:0]    raddr, waddr;
    logic [KEY_BITS-1:0] wdata;
    logic                we;

    assign cnt_m1 = count_reg - CNT_W'(1);

    always_comb begin
        raddr = scan_reg[IDX_W-1:0];
        if (cmd.rd_last) raddr = cnt_m1[IDX_W-1:0];
        else if (cmd.rd_pos) raddr = pos_reg[IDX_W-1:0];
        we = cmd.wr_append | cmd.wr_move;
        waddr = cmd.wr_append ? count_reg[IDX_W-1:0] : scan_reg[IDX_W-1:0];
        wdata = cmd.wr_append ? key_reg : rdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (cmd.rd | cmd.rd_last | cmd.rd_pos) rdata_reg <= mem[raddr];
        if (cmd.load) begin
            key_reg <= in_key[KEY_BITS-1:0];
            op_reg  <= op_t'(in_op);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clr) count_next = '0;
        else if (cmd.wr_append) count_next = count_reg + CNT_W'(1);
        else if (cmd.wr_move) count_next = cnt_m1;
        pos_next = pos_reg;
        if (cmd.rewind) pos_next = '0;
        else if (cmd.pos_inc) pos_next = pos_reg + CNT_W'(1);
        scan_next = scan_reg;
        if (cmd.scan_rst) scan_next = '0;
        else if (cmd.scan_inc) scan_next = scan_reg + CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pos_reg   <= '0;
            scan_reg  <= '0;
            m_valid   <= 1'b0;
        end else begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
            scan_reg  <= scan_next;
            if (cmd.emit) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    // Result register; count fields reflect state after this command's update.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status      <= cmd.status;
            m_found       <= cmd.found;
            m_value       <= cmd.use_val ? 32'(rdata_reg) : '0;
            m_below_pivot <= cmd.below_en & (rdata_reg < key_reg);
            m_last        <= cmd.last;
            m_entry_count <= count_next;
            m_is_full     <= (count_next == CNT_W'(CAPACITY));
            m_is_empty    <= (count_next == '0);
        end
    end

    assign sts.op         = op_reg;
    assign sts.match      = (rdata_reg == key_reg);
    assign sts.scan_done  = (scan_reg >= count_reg);
    assign sts.scan_final = (scan_reg == cnt_m1);
    assign sts.full       = (count_reg >= CNT_W'(CAPACITY));
    assign sts.empty      = (count_reg == '0);
    assign sts.pos_ok     = (pos_reg < count_reg);
    assign sts.out_busy   = m_valid & ~m_ready;
endmodule
`default_nettype wire

// ----- hdl/ukt_ctrl.sv -----
`default_nettype none
module ukt_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ukt_pkg::ukt_sts_t  sts,
    output ukt_pkg::ukt_cmd_t       cmd
);
    import ukt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_READ, S_CHECK, S_MOVE_RD, S_MOVE_WR, S_EMIT, S_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   hit_reg, hit_next;
    logic   ready_next;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        hit_next = hit_reg;
        ready_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                ready_next = 1'b1;
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    cmd.scan_rst = 1'b1;
                    hit_next = 1'b0;
                    ready_next = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.op)
                    OP_CLEAR, OP_REWIND: begin
                        if (!sts.out_busy) begin
                            cmd.clr = (sts.op == OP_CLEAR);
                            cmd.rewind = (sts.op == OP_REWIND);
                            cmd.emit = 1'b1; cmd.status = ST_OK; cmd.last = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    OP_NEXT: begin
                        if (sts.pos_ok) begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_EMIT;
                        end else if (!sts.out_busy) begin
                            cmd.emit = 1'b1; cmd.status = ST_END; cmd.last = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    OP_INSERT: begin
                        if (sts.full) begin
                            if (!sts.out_busy) begin
                                cmd.emit = 1'b1; cmd.status = ST_FULL; cmd.last = 1'b1;
                                state_next = S_WAIT;
                            end
                        end else state_next = S_READ;
                    end
                    OP_SPLIT: begin
                        if (sts.empty) begin
                            if (!sts.out_busy) begin
                                cmd.emit = 1'b1; cmd.status = ST_END; cmd.last = 1'b1;
                                state_next = S_WAIT;
                            end
                        end else state_next = S_READ;
                    end
                    default: state_next = S_READ;
                endcase
            end
            S_READ: begin
                // Scan finished without a decisive hit.
                if (sts.scan_done) begin
                    if (!sts.out_busy) begin
                        cmd.emit = 1'b1; cmd.last = 1'b1;
                        case (sts.op)
                            OP_INSERT: begin
                                cmd.wr_append = 1'b1; cmd.status = ST_OK;
                            end
                            OP_DEL_ALL: begin
                                cmd.status = hit_reg ? ST_OK : ST_MISS;
                                cmd.found = hit_reg;
                            end
                            default: cmd.status = ST_MISS;
                        endcase
                        state_next = S_WAIT;
                    end
                end else begin
                    cmd.rd = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                case (sts.op)
                    OP_SPLIT: begin
                        if (!sts.out_busy) begin
                            cmd.emit = 1'b1; cmd.status = ST_OK; cmd.use_val = 1'b1;
                            cmd.below_en = 1'b1; cmd.last = sts.scan_final;
                            cmd.scan_inc = 1'b1;
                            state_next = sts.scan_final ? S_WAIT : S_READ;
                        end
                    end
                    default: begin
                        if (!sts.match) begin
                            cmd.scan_inc = 1'b1;
                            state_next = S_READ;
                        end else if (sts.op == OP_DEL_ONE || sts.op == OP_DEL_ALL) begin
                            hit_next = 1'b1;
                            state_next = S_MOVE_RD;
                        end else if (!sts.out_busy) begin
                            cmd.emit = 1'b1; cmd.last = 1'b1;
                            cmd.status = (sts.op == OP_INSERT) ? ST_DUP : ST_OK;
                            cmd.found = (sts.op == OP_LOOKUP);
                            cmd.use_val = (sts.op == OP_LOOKUP);
                            state_next = S_WAIT;
                        end
                    end
                endcase
            end
            S_MOVE_RD: begin
                cmd.rd_last = 1'b1;
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                if (sts.op == OP_DEL_ALL) begin
                    cmd.wr_move = 1'b1;
                    state_next = S_READ;
                end else if (!sts.out_busy) begin
                    cmd.wr_move = 1'b1;
                    cmd.emit = 1'b1; cmd.status = ST_OK; cmd.found = 1'b1; cmd.last = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.emit = 1'b1; cmd.status = ST_OK; cmd.use_val = 1'b1;
                    cmd.last = 1'b1; cmd.pos_inc = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                ready_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hit_reg   <= 1'b0;
            s_ready   <= 1'b0;
        end else begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
            s_ready   <= ready_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/unsorted_key_table.sv -----
// Unordered key table of 32 entries. One transaction on s_ carries an op and a
// key; every op returns one result on m_ with last set, but a nonempty split
// returns one per stored entry in stored order (last on the final one).
// Insert, delete, lookup and split scan the stored entries one at a time
// through the entry memory, with a read state and a check state for each
// entry; clear, rewind and next do not scan. A deletion moves the last entry
// into each removed slot with a read and then a write, and a result that
// m_ready holds back stalls the operation until it is taken.
// s_ready is registered and drops for the whole of an operation; the result
// register lets the next item in while the final result is still waiting.
// Entries are not cleared at reset: only slots below the count are ever read.
`default_nettype none
module unsorted_key_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [31:0] s_key,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic             m_found,
    output logic [31:0]      m_value,
    output logic             m_below_pivot,
    output logic             m_last,
    output logic [5:0]       m_entry_count,
    output logic             m_is_full,
    output logic             m_is_empty
);
    import ukt_pkg::*;

    ukt_cmd_t cmd;
    ukt_sts_t sts;

    // Sequence each operation.
    ukt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    // Hold entries, count, read position and the result register.
    ukt_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_op(s_op), .in_key(s_key),
        .cmd(cmd), .sts(sts), .m_ready(m_ready), .m_valid(m_valid),
        .m_status(m_status), .m_found(m_found), .m_value(m_value),
        .m_below_pivot(m_below_pivot), .m_last(m_last),
        .m_entry_count(m_entry_count), .m_is_full(m_is_full),
        .m_is_empty(m_is_empty)
    );
endmodule
`default_nettype wire

// ----- hdl/ukt_checker.sv -----
`default_nettype none
`include "unsorted_key_table_assert.svh"
module ukt_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_status,
    input wire logic [5:0] m_entry_count,
    input wire logic       m_is_full,
    input wire logic       m_is_empty
);
    `UKT_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status), "result changed while stalled")
    `UKT_ASSERT_IMP(a_full, aclk, aresetn, m_valid, m_is_full == (m_entry_count == 6'd32), "full flag mismatch")
    `UKT_ASSERT_IMP(a_empty, aclk, aresetn, m_valid, m_is_empty == (m_entry_count == 6'd0), "empty flag mismatch")
    `UKT_ASSERT_IMP(a_cnt, aclk, aresetn, m_valid, m_entry_count <= 6'd32, "count beyond capacity")
    `UKT_ASSERT_NXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "ready stayed high after accept")
endmodule
bind unsorted_key_table ukt_checker u_ukt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_entry_count(m_entry_count), .m_is_full(m_is_full),
    .m_is_empty(m_is_empty)
);
`default_nettype wire
